### src/edr_pkg.sv
// edr_pkg: shared types, codes and constants of the encoder dead reckoning block
// holds the microprogram rom, the control word layout and the sine polynomial terms
// no dependencies
package edr_pkg;

  // request codes of a command word
  localparam int REQ_W = 2;
  localparam logic [REQ_W-1:0] REQ_LEFT   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RIGHT  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd2;

  // field widths
  localparam int YAW_W  = 16;
  localparam int POS_W  = 40;
  localparam int MPC_W  = 22;
  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;

  // apb register file
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_LEFT_MPC  = 1'b0;
  localparam logic REG_RIGHT_MPC = 1'b1;
  localparam logic [MPC_W-1:0] LEFT_MPC_RESET  = 22'd161945;
  localparam logic [MPC_W-1:0] RIGHT_MPC_RESET = 22'd161947;

  localparam logic [MUL_W-1:0] LO24_MASK = 32'h00FF_FFFF;

  // odd sine polynomial in q30, horner order
  localparam logic [31:0] K9 = 32'd172272;
  localparam int HORN_IDX_W = 2;
  localparam logic [HORN_IDX_W-1:0] HORN_LAST = 2'd3;

  function automatic logic [31:0] horner_coef(input logic [HORN_IDX_W-1:0] idx);
    logic [31:0] k;
    unique case (idx)
      2'd0: k = 32'd5026995;
      2'd1: k = 32'd85569306;
      2'd2: k = 32'd693598668;
      2'd3: k = 32'd1686629713;
    endcase
    return k;
  endfunction

  // multiplier operand selects
  localparam int MULSEL_W = 3;
  localparam logic [MULSEL_W-1:0] MUL_NONE = 3'd0;
  localparam logic [MULSEL_W-1:0] MUL_WHI  = 3'd1;
  localparam logic [MULSEL_W-1:0] MUL_WLO  = 3'd2;
  localparam logic [MULSEL_W-1:0] MUL_XX   = 3'd3;
  localparam logic [MULSEL_W-1:0] MUL_HORN = 3'd4;
  localparam logic [MULSEL_W-1:0] MUL_XP   = 3'd5;
  localparam logic [MULSEL_W-1:0] MUL_THI  = 3'd6;
  localparam logic [MULSEL_W-1:0] MUL_TLO  = 3'd7;

  // datapath actions
  localparam int ACT_W = 4;
  localparam logic [ACT_W-1:0] ACT_NOP   = 4'd0;
  localparam logic [ACT_W-1:0] ACT_WCAP  = 4'd1;
  localparam logic [ACT_W-1:0] ACT_WDIST = 4'd2;
  localparam logic [ACT_W-1:0] ACT_WACC  = 4'd3;
  localparam logic [ACT_W-1:0] ACT_AVG   = 4'd4;
  localparam logic [ACT_W-1:0] ACT_AMAG  = 4'd5;
  localparam logic [ACT_W-1:0] ACT_SINIT = 4'd6;
  localparam logic [ACT_W-1:0] ACT_X2    = 4'd7;
  localparam logic [ACT_W-1:0] ACT_HORN  = 4'd8;
  localparam logic [ACT_W-1:0] ACT_SRND  = 4'd9;
  localparam logic [ACT_W-1:0] ACT_THI   = 4'd10;
  localparam logic [ACT_W-1:0] ACT_TSUM  = 4'd11;
  localparam logic [ACT_W-1:0] ACT_TSGN  = 4'd12;
  localparam logic [ACT_W-1:0] ACT_POS   = 4'd13;
  localparam logic [ACT_W-1:0] ACT_EMIT  = 4'd14;

  // sequencing
  localparam int JMP_W = 2;
  localparam logic [JMP_W-1:0] JMP_NEXT = 2'd0;
  localparam logic [JMP_W-1:0] JMP_PASS = 2'd1;
  localparam logic [JMP_W-1:0] JMP_HORN = 2'd2;
  localparam logic [JMP_W-1:0] JMP_END  = 2'd3;

  localparam int UC_STEP_W = 5;
  localparam logic [UC_STEP_W-1:0] UA_WHEEL = 5'd0;
  localparam logic [UC_STEP_W-1:0] UA_SINE  = 5'd6;
  localparam logic [UC_STEP_W-1:0] UA_HORN  = 5'd9;
  localparam logic [UC_STEP_W-1:0] UA_AXIS  = 5'd13;

  typedef struct packed {
    logic [MULSEL_W-1:0]  mul;
    logic [ACT_W-1:0]     act;
    logic [JMP_W-1:0]     jmp;
    logic [UC_STEP_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic                  busy;
    logic                  pass;
    logic [HORN_IDX_W-1:0] kidx;
    ucode_t                cw;
  } seq_stat_t;

  function automatic ucode_t ucode_word(input logic [UC_STEP_W-1:0] step);
    ucode_t w;
    unique case (step)
      // wheel distance, left then right
      5'd0:  w = '{mul: MUL_WHI,  act: ACT_NOP,   jmp: JMP_NEXT, target: UA_WHEEL};
      5'd1:  w = '{mul: MUL_WLO,  act: ACT_WCAP,  jmp: JMP_NEXT, target: UA_WHEEL};
      5'd2:  w = '{mul: MUL_NONE, act: ACT_WDIST, jmp: JMP_NEXT, target: UA_WHEEL};
      5'd3:  w = '{mul: MUL_NONE, act: ACT_WACC,  jmp: JMP_PASS, target: UA_WHEEL};
      5'd4:  w = '{mul: MUL_NONE, act: ACT_AVG,   jmp: JMP_NEXT, target: UA_WHEEL};
      5'd5:  w = '{mul: MUL_NONE, act: ACT_AMAG,  jmp: JMP_NEXT, target: UA_WHEEL};
      // sine then cosine
      5'd6:  w = '{mul: MUL_NONE, act: ACT_SINIT, jmp: JMP_NEXT, target: UA_SINE};
      5'd7:  w = '{mul: MUL_XX,   act: ACT_NOP,   jmp: JMP_NEXT, target: UA_SINE};
      5'd8:  w = '{mul: MUL_NONE, act: ACT_X2,    jmp: JMP_NEXT, target: UA_SINE};
      5'd9:  w = '{mul: MUL_HORN, act: ACT_NOP,   jmp: JMP_NEXT, target: UA_HORN};
      5'd10: w = '{mul: MUL_NONE, act: ACT_HORN,  jmp: JMP_HORN, target: UA_HORN};
      5'd11: w = '{mul: MUL_XP,   act: ACT_NOP,   jmp: JMP_NEXT, target: UA_SINE};
      5'd12: w = '{mul: MUL_NONE, act: ACT_SRND,  jmp: JMP_PASS, target: UA_SINE};
      // x then y projection
      5'd13: w = '{mul: MUL_THI,  act: ACT_NOP,   jmp: JMP_NEXT, target: UA_AXIS};
      5'd14: w = '{mul: MUL_TLO,  act: ACT_THI,   jmp: JMP_NEXT, target: UA_AXIS};
      5'd15: w = '{mul: MUL_NONE, act: ACT_TSUM,  jmp: JMP_NEXT, target: UA_AXIS};
      5'd16: w = '{mul: MUL_NONE, act: ACT_TSGN,  jmp: JMP_NEXT, target: UA_AXIS};
      5'd17: w = '{mul: MUL_NONE, act: ACT_POS,   jmp: JMP_PASS, target: UA_AXIS};
      5'd18: w = '{mul: MUL_NONE, act: ACT_EMIT,  jmp: JMP_END,  target: UA_WHEEL};
      default: w = '{mul: MUL_NONE, act: ACT_NOP, jmp: JMP_END, target: UA_WHEEL};
    endcase
    return w;
  endfunction

endpackage

### src/edr_if.sv
// edr_cmd_if and edr_pose_if: valid/ready channels of the dead reckoning block
// command words in, pose words out
// depends on edr_pkg
interface edr_cmd_if;
  import edr_pkg::*;

  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic             pulse_dir;
  logic [YAW_W-1:0] yaw_angle;

  modport source (output valid, req_type, pulse_dir, yaw_angle, input ready);
  modport sink   (input valid, req_type, pulse_dir, yaw_angle, output ready);
endinterface

interface edr_pose_if;
  import edr_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pose_x;
  logic signed [POS_W-1:0] pose_y;
  logic [YAW_W-1:0]        heading;

  modport source (output valid, pose_x, pose_y, heading, input ready);
  modport sink   (input valid, pose_x, pose_y, heading, output ready);
endinterface

### src/edr_mul.sv
// edr_mul: shared 32x32 unsigned multiplier with registered product
// depends on edr_pkg
module edr_mul (
  input  logic                         clk,
  input  logic [edr_pkg::MUL_W-1:0]    a,
  input  logic [edr_pkg::MUL_W-1:0]    b,
  output logic [edr_pkg::PROD_W-1:0]   prod
);
  import edr_pkg::*;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

### src/edr_useq.sv
// edr_useq: microprogram sequencer, step counter over the control rom
// loop bit and horner index drive the conditional jumps
// depends on edr_pkg
module edr_useq (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                hold,
  output edr_pkg::seq_stat_t  stat
);
  import edr_pkg::*;

  logic [UC_STEP_W-1:0]  step;
  logic                  busy;
  logic                  pass;
  logic [HORN_IDX_W-1:0] kidx;
  ucode_t                cw;

  assign cw = ucode_word(step);

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
      busy <= 1'b0;
      pass <= 1'b0;
      kidx <= '0;
    end else if (start) begin
      step <= '0;
      busy <= 1'b1;
      pass <= 1'b0;
      kidx <= '0;
    end else if (busy && !hold) begin
      unique case (cw.jmp)
        JMP_NEXT: step <= step + 1'b1;
        JMP_PASS: begin
          // run a routine twice, second pass falls through
          if (!pass) begin
            pass <= 1'b1;
            step <= cw.target;
          end else begin
            pass <= 1'b0;
            step <= step + 1'b1;
          end
        end
        JMP_HORN: begin
          if (kidx != HORN_LAST) begin
            kidx <= kidx + 1'b1;
            step <= cw.target;
          end else begin
            kidx <= '0;
            step <= step + 1'b1;
          end
        end
        JMP_END: begin
          busy <= 1'b0;
          step <= '0;
        end
      endcase
    end
  end

  assign stat = '{busy: busy, pass: pass, kidx: kidx, cw: cw};

endmodule

### src/encoder_dead_reckoning.sv
// encoder_dead_reckoning: two-wheel encoder counters and pose integrator
// depends on edr_pkg, edr_if, edr_mul, edr_useq
//
//   channel  dir   handshake            word
//   cmd      in    valid/ready          req_type, pulse_dir, yaw_angle
//   pose     out   valid/ready          pose_x, pose_y, heading
//   apb      in    psel/penable/pready  mm-per-count registers at 0x0 and 0x4
//
// on a pulse word cmd.ready stays high
// an update word runs a 19-word microprogram on one shared 32x32 multiplier:
//   cmd.ready is low from acceptance until pose.valid is raised
// the last step waits while a previous pose word is still unread
// reset (rst, synchronous) clears counts, positions and registers to defaults
module encoder_dead_reckoning #(
  parameter int COUNT_WIDTH = 32,
  parameter int ANGLE_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  edr_cmd_if.sink                            cmd,
  edr_pose_if.source                         pose,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [edr_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [edr_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [edr_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import edr_pkg::*;

  localparam int X_SHIFT = 32 - ANGLE_BITS;
  localparam logic [ANGLE_BITS-1:0] QUARTER   = {2'b01, {(ANGLE_BITS-2){1'b0}}};
  localparam logic [ANGLE_BITS-2:0] QUARTER_Q = {1'b1, {(ANGLE_BITS-2){1'b0}}};
  localparam logic [61:0] DIST_CAP = {1'b1, 61'b0};
  localparam logic signed [63:0] AVG_CAP = 64'sh0000_0200_0000_0000;
  localparam logic signed [57:0] RND_HALF = 58'sd16384;
  localparam logic signed [POS_W+3:0] POS_MAX = 44'sd549755813887;
  localparam logic signed [POS_W+3:0] POS_MIN = -44'sd549755813888;

  // architectural state
  logic [COUNT_WIDTH-1:0]  count_l, count_r, last_l, last_r;
  logic signed [POS_W-1:0] pos_x, pos_y;
  logic [MPC_W-1:0]        mpc_l, mpc_r;
  logic                    out_valid;

  // per-update working registers
  logic [COUNT_WIDTH-1:0]  d_l, d_r;
  logic [ANGLE_BITS-1:0]   ang;
  logic [YAW_W-1:0]        heading_r;
  logic                    wcap;
  logic [36:0]             whi;
  logic [61:0]             dist_mag;
  logic signed [63:0]      dsum;
  logic signed [42:0]      avg;
  logic [41:0]             avg_mag;
  logic                    avg_neg;
  logic [30:0]             x, x2;
  logic [31:0]             p;
  logic                    s_neg;
  logic [15:0]             sn_mag, cs_mag;
  logic                    sn_neg, cs_neg;
  logic [32:0]             thi;
  logic [56:0]             pmag;
  logic signed [57:0]      stepv;
  logic signed [POS_W-1:0] out_x, out_y;
  logic [YAW_W-1:0]        out_heading;

  seq_stat_t         stat;
  logic              cmd_fire, start, emit_wait;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod;

  assign cmd.ready = !stat.busy;
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign start     = cmd_fire && (cmd.req_type == REQ_UPDATE);
  assign emit_wait = (stat.cw.act == ACT_EMIT) && out_valid && !pose.ready;

  edr_useq u_useq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .hold  (emit_wait),
    .stat  (stat)
  );

  edr_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // angle reduced to ANGLE_BITS
  logic [ANGLE_BITS+15:0] yaw_wide;
  logic [ANGLE_BITS-1:0]  ang_in;
  assign yaw_wide = {cmd.yaw_angle, ANGLE_BITS'(0)};
  assign ang_in   = yaw_wide[ANGLE_BITS+15:16];

  // wheel selected by the loop bit
  logic [COUNT_WIDTH-1:0] d_sel, w_mag;
  logic                   w_neg;
  logic [MPC_W-1:0]       mpc_sel;
  assign d_sel   = stat.pass ? d_r : d_l;
  assign w_neg   = d_sel[COUNT_WIDTH-1];
  assign w_mag   = w_neg ? (~d_sel + 1'b1) : d_sel;
  assign mpc_sel = stat.pass ? mpc_r : mpc_l;

  // axis selected by the loop bit: cosine feeds x, sine feeds y
  logic [15:0] trig_mag;
  logic        trig_neg;
  assign trig_mag = stat.pass ? sn_mag : cs_mag;
  assign trig_neg = stat.pass ? sn_neg : cs_neg;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (stat.cw.mul)
      MUL_NONE: ;
      MUL_WHI: begin
        mul_a = MUL_W'(w_mag >> 24);
        mul_b = MUL_W'(mpc_sel);
      end
      MUL_WLO: begin
        mul_a = MUL_W'(w_mag) & LO24_MASK;
        mul_b = MUL_W'(mpc_sel);
      end
      MUL_XX: begin
        mul_a = MUL_W'(x);
        mul_b = MUL_W'(x);
      end
      MUL_HORN: begin
        mul_a = MUL_W'(x2);
        mul_b = p;
      end
      MUL_XP: begin
        mul_a = MUL_W'(x);
        mul_b = p;
      end
      MUL_THI: begin
        mul_a = MUL_W'(avg_mag >> 24);
        mul_b = MUL_W'(trig_mag);
      end
      MUL_TLO: begin
        mul_a = MUL_W'(avg_mag) & LO24_MASK;
        mul_b = MUL_W'(trig_mag);
      end
    endcase
  end

  // combinational pieces of the datapath actions
  logic [61:0]             psum;
  logic signed [63:0]      dist_s, avg_sh, avg_next;
  logic [ANGLE_BITS-1:0]   ang_p;
  logic [ANGLE_BITS-2:0]   q, q_eff;
  logic [32:0]             s_rnd;
  logic [17:0]             s_raw;
  logic [15:0]             s_cap;
  logic signed [57:0]      pmag_s, st;
  logic signed [POS_W+3:0] pos_sum;
  logic signed [POS_W-1:0] pos_sel, pos_next;

  always_comb begin
    psum     = 62'({whi, 24'b0}) + 62'(prod[45:0]);
    dist_s   = $signed({2'b00, dist_mag});
    avg_sh   = dsum >>> 9;
    if (avg_sh > AVG_CAP) begin
      avg_next = AVG_CAP;
    end else if (avg_sh < -AVG_CAP) begin
      avg_next = -AVG_CAP;
    end else begin
      avg_next = avg_sh;
    end
    ang_p    = stat.pass ? (ang + QUARTER) : ang;
    q        = {1'b0, ang_p[ANGLE_BITS-3:0]};
    // mirror the second and fourth quadrants
    q_eff    = ang_p[ANGLE_BITS-2] ? (QUARTER_Q - q) : q;
    s_rnd    = {1'b0, prod[61:30]} + 33'd16384;
    s_raw    = s_rnd[32:15];
    s_cap    = (s_raw > 18'd32768) ? 16'h8000 : s_raw[15:0];
    pmag_s   = $signed({1'b0, pmag});
    st       = stepv >>> 15;
    pos_sel  = stat.pass ? pos_y : pos_x;
    pos_sum  = (POS_W+4)'(pos_sel) + (POS_W+4)'(st);
    if (pos_sum > POS_MAX) begin
      pos_next = POS_MAX[POS_W-1:0];
    end else if (pos_sum < POS_MIN) begin
      pos_next = POS_MIN[POS_W-1:0];
    end else begin
      pos_next = pos_sum[POS_W-1:0];
    end
  end

  // counters, positions, registers, output flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count_l   <= '0;
      count_r   <= '0;
      last_l    <= '0;
      last_r    <= '0;
      pos_x     <= '0;
      pos_y     <= '0;
      mpc_l     <= LEFT_MPC_RESET;
      mpc_r     <= RIGHT_MPC_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cmd_fire) begin
        case (cmd.req_type)
          REQ_LEFT:  count_l <= cmd.pulse_dir ? count_l + 1'b1 : count_l - 1'b1;
          REQ_RIGHT: count_r <= cmd.pulse_dir ? count_r + 1'b1 : count_r - 1'b1;
          REQ_UPDATE: begin
            last_l <= count_l;
            last_r <= count_r;
          end
          default: ;
        endcase
      end
      if (psel && penable && pwrite) begin
        unique case (paddr[2])
          REG_LEFT_MPC:  mpc_l <= pwdata[MPC_W-1:0];
          REG_RIGHT_MPC: mpc_r <= pwdata[MPC_W-1:0];
        endcase
      end
      if (stat.busy && stat.cw.act == ACT_POS) begin
        if (stat.pass) begin
          pos_y <= pos_next;
        end else begin
          pos_x <= pos_next;
        end
      end
      // a new word replaces the one read out in the same cycle
      if (stat.busy && stat.cw.act == ACT_EMIT && !emit_wait) begin
        out_valid <= 1'b1;
      end else if (pose.valid && pose.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath working registers
  always_ff @(posedge clk) begin
    if (start) begin
      d_l       <= count_l - last_l;
      d_r       <= count_r - last_r;
      ang       <= ang_in;
      heading_r <= cmd.yaw_angle;
      dsum      <= '0;
    end else if (stat.busy) begin
      unique case (stat.cw.act)
        ACT_NOP: ;
        ACT_WCAP: begin
          wcap <= |prod[PROD_W-1:37];
          whi  <= prod[36:0];
        end
        ACT_WDIST: dist_mag <= (wcap || psum > DIST_CAP) ? DIST_CAP : psum;
        ACT_WACC:  dsum <= w_neg ? (dsum - dist_s) : (dsum + dist_s);
        ACT_AVG:   avg <= avg_next[42:0];
        ACT_AMAG: begin
          avg_neg <= avg[42];
          avg_mag <= avg[42] ? 42'(-avg) : 42'(avg);
        end
        ACT_SINIT: begin
          x     <= 31'(q_eff) << X_SHIFT;
          s_neg <= ang_p[ANGLE_BITS-1];
        end
        ACT_X2: begin
          x2 <= prod[60:30];
          p  <= K9;
        end
        ACT_HORN: p <= horner_coef(stat.kidx) - prod[61:30];
        ACT_SRND: begin
          if (stat.pass) begin
            cs_mag <= s_cap;
            cs_neg <= s_neg;
          end else begin
            sn_mag <= s_cap;
            sn_neg <= s_neg;
          end
        end
        ACT_THI:  thi <= prod[32:0];
        ACT_TSUM: pmag <= {thi, 24'b0} + 57'(prod[38:0]);
        ACT_TSGN: stepv <= (avg_neg ^ trig_neg) ? (RND_HALF - pmag_s) : (pmag_s + RND_HALF);
        ACT_POS:  ;
        ACT_EMIT: begin
          if (!emit_wait) begin
            out_x       <= pos_x;
            out_y       <= pos_y;
            out_heading <= heading_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign pose.valid   = out_valid;
  assign pose.pose_x  = out_x;
  assign pose.pose_y  = out_y;
  assign pose.heading = out_heading;

  // apb read side
  always_comb begin
    unique case (paddr[2])
      REG_LEFT_MPC:  prdata = CFG_DATA_W'(mpc_l);
      REG_RIGHT_MPC: prdata = CFG_DATA_W'(mpc_r);
    endcase
  end

  assign pready = 1'b1;

endmodule

### src/edr_checker.sv
// edr_checker: port-level checks of encoder_dead_reckoning, attached by bind
// depends on edr_pkg and the top level's channel interfaces
module edr_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              cmd_valid,
  input logic                              cmd_ready,
  input logic [edr_pkg::REQ_W-1:0]         cmd_req_type,
  input logic                              pose_valid,
  input logic                              pose_ready,
  input logic signed [edr_pkg::POS_W-1:0]  pose_x,
  input logic signed [edr_pkg::POS_W-1:0]  pose_y,
  input logic [edr_pkg::YAW_W-1:0]         heading
);
  import edr_pkg::*;

  // a stalled pose word holds
  a_pose_hold: assert property (@(posedge clk) disable iff (rst)
    pose_valid && !pose_ready |=> pose_valid && $stable(pose_x) && $stable(pose_y)
      && $stable(heading))
    else $error("pose word changed while stalled");

  // an update occupies the sequencer
  a_update_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && cmd_req_type == REQ_UPDATE |=> !cmd_ready)
    else $error("ready stayed high after an update");

  // pulses never block the command channel
  a_pulse_free: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && cmd_req_type != REQ_UPDATE |=> cmd_ready)
    else $error("ready dropped after a pulse word");

  // a pose word only appears at the end of an update run
  a_pose_source: assert property (@(posedge clk) disable iff (rst)
    $rose(pose_valid) |-> $past(!cmd_ready))
    else $error("pose word without an update in progress");

endmodule

bind encoder_dead_reckoning edr_checker u_edr_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_valid    (cmd.valid),
  .cmd_ready    (cmd.ready),
  .cmd_req_type (cmd.req_type),
  .pose_valid   (pose.valid),
  .pose_ready   (pose.ready),
  .pose_x       (pose.pose_x),
  .pose_y       (pose.pose_y),
  .heading      (pose.heading)
);

### tb/sv/encoder_dead_reckoning_tb.sv
`timescale 1ns / 1ps
// encoder_dead_reckoning_tb: random and directed pulse/update traffic against a bit-exact
// odometry predictor, with bursty command flow, pose back-pressure and apb scale writes
// depends on edr_pkg, edr_if and encoder_dead_reckoning
module encoder_dead_reckoning_tb;
  import edr_pkg::*;

  localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;
  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [MPC_W-1:0] SCALE_MAX = 22'h3F_FFFF;

  localparam longint unsigned DIST_CAP = 64'h2000_0000_0000_0000;
  localparam longint AVG_CAP = 64'sh200_0000_0000;
  localparam longint POS_MAX = 64'sh7F_FFFF_FFFF;
  localparam longint POS_MIN = -POS_MAX - 64'sd1;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             dir;
    logic [YAW_W-1:0] yaw;
  } cmd_word_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pose_x;
    logic signed [POS_W-1:0] pose_y;
    logic [YAW_W-1:0]        heading;
  } pose_word_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  edr_cmd_if  cmd_ch ();
  edr_pose_if pose_ch ();

  encoder_dead_reckoning u_top (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .pose    (pose_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  logic [31:0] left_ticks, right_ticks, left_ticks_seen, right_ticks_seen;
  logic signed [POS_W-1:0] track_x, track_y;
  logic [MPC_W-1:0] left_scale, right_scale;

  cmd_word_t  cmd_queue[$];
  pose_word_t pose_expected[$];

  int errors = 0;
  int cycles = 0;
  bit cmd_fire = 1'b0;
  int burst_left = 1;
  int gap_left = 0;
  int stall_left = 0;
  int stall_pct = 0;
  int stall_max = 4;
  int recv_cycles = 0;

  // signed q16 mm travelled by one wheel since its last update
  function automatic longint wheel_travel(input logic [31:0] cur, input logic [31:0] prev,
                                          input logic [MPC_W-1:0] scale);
    logic [31:0] d;
    logic [31:0] mag;
    longint unsigned m, hi, lo, p;
    d = cur - prev;
    mag = d[31] ? (~d + 32'd1) : d;
    m = 64'(mag);
    hi = (m >> 24) * scale;
    lo = (m & 64'hFF_FFFF) * scale;
    if (hi >= (64'd1 << 37)) begin
      p = DIST_CAP;
    end else begin
      p = (hi << 24) + lo;
      if (p > DIST_CAP) p = DIST_CAP;
    end
    return d[31] ? -longint'(p) : longint'(p);
  endfunction

  // q15 sine over the first quadrant, odd polynomial evaluated in q30
  function automatic longint quarter_wave(input longint unsigned q);
    longint unsigned x, x2, acc, s;
    x = q << 16;
    x2 = (x * x) >> 30;
    acc = 64'd172272;
    acc = 64'd5026995 - ((x2 * acc) >> 30);
    acc = 64'd85569306 - ((x2 * acc) >> 30);
    acc = 64'd693598668 - ((x2 * acc) >> 30);
    acc = 64'd1686629713 - ((x2 * acc) >> 30);
    s = (x * acc) >> 30;
    s = (s + 64'd16384) >> 15;
    if (s > 64'd32768) s = 64'd32768;
    return longint'(s);
  endfunction

  function automatic longint sine_q15(input logic [YAW_W-1:0] ang);
    longint unsigned q;
    longint s;
    q = 64'(ang[13:0]);
    s = ang[14] ? quarter_wave(64'd16384 - q) : quarter_wave(q);
    return ang[15] ? -s : s;
  endfunction

  function automatic logic signed [POS_W-1:0] pos_accumulate(
      input logic signed [POS_W-1:0] pos, input longint avg, input longint trig);
    longint step, r;
    step = (avg * trig + 64'sd16384) >>> 15;
    r = pos + step;
    if (r > POS_MAX) r = POS_MAX;
    if (r < POS_MIN) r = POS_MIN;
    return r[POS_W-1:0];
  endfunction

  // advances the odometry state by one command word, returns 1 when a pose comes out
  function automatic bit odometry_step(input cmd_word_t w, output pose_word_t p);
    longint dl, dr, avg;
    logic [YAW_W-1:0] cos_ang;
    p = '0;
    case (w.req)
      REQ_LEFT: begin
        left_ticks = left_ticks + (w.dir ? 32'd1 : 32'hFFFF_FFFF);
        return 1'b0;
      end
      REQ_RIGHT: begin
        right_ticks = right_ticks + (w.dir ? 32'd1 : 32'hFFFF_FFFF);
        return 1'b0;
      end
      REQ_UPDATE: begin
        dl = wheel_travel(left_ticks, left_ticks_seen, left_scale);
        dr = wheel_travel(right_ticks, right_ticks_seen, right_scale);
        left_ticks_seen = left_ticks;
        right_ticks_seen = right_ticks;
        avg = (dl + dr) >>> 9;
        if (avg > AVG_CAP) avg = AVG_CAP;
        if (avg < -AVG_CAP) avg = -AVG_CAP;
        cos_ang = w.yaw + 16'd16384;
        track_x = pos_accumulate(track_x, avg, sine_q15(cos_ang));
        track_y = pos_accumulate(track_y, avg, sine_q15(w.yaw));
        p.pose_x = track_x;
        p.pose_y = track_y;
        p.heading = w.yaw;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void set_scale(input logic idx, input logic [CFG_DATA_W-1:0] value);
    if (idx == REG_LEFT_MPC) left_scale = value[MPC_W-1:0];
    else right_scale = value[MPC_W-1:0];
  endfunction

  function automatic logic [YAW_W-1:0] pick_yaw();
    logic [YAW_W-1:0] y;
    if ($urandom_range(0, 9) != 0) return YAW_W'($urandom_range(0, 65535));
    case ($urandom_range(0, 8))
      0: y = 16'h0000;
      1: y = 16'h4000;
      2: y = 16'h8000;
      3: y = 16'hC000;
      4: y = 16'hFFFF;
      5: y = 16'h3FFF;
      6: y = 16'h7FFF;
      7: y = 16'h2000;
      default: y = 16'h0001;
    endcase
    return y;
  endfunction

  function automatic void push_cmd(input logic [REQ_W-1:0] req, input logic dir,
                                   input logic [YAW_W-1:0] yaw);
    cmd_word_t w;
    w.req = req;
    w.dir = dir;
    w.yaw = yaw;
    cmd_queue.push_back(w);
  endfunction

  always #5 clk = ~clk;

  // command sender: bursts of random length with random gaps
  always @(negedge clk) begin
    if (!rst && (!cmd_ch.valid || cmd_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        cmd_ch.valid <= 1'b0;
      end else if (cmd_queue.size() > 0) begin
        cmd_ch.valid     <= 1'b1;
        cmd_ch.req_type  <= cmd_queue[0].req;
        cmd_ch.pulse_dir <= cmd_queue[0].dir;
        cmd_ch.yaw_angle <= cmd_queue[0].yaw;
        void'(cmd_queue.pop_front());
        if (burst_left > 1) begin
          burst_left--;
        end else if ($urandom_range(0, 3) == 0) begin
          burst_left = $urandom_range(20, 60);
          gap_left = 0;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left = $urandom_range(1, 10);
        end
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // pose receiver: random stalls whose density is redrawn at regular intervals
  always @(negedge clk) begin
    if (!rst) begin
      recv_cycles++;
      if (recv_cycles % 400 == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 10;
          2: stall_pct = 40;
          default: stall_pct = 80;
        endcase
        stall_max = $urandom_range(1, 30);
      end
      if (stall_left > 0) begin
        stall_left--;
        pose_ch.ready <= 1'b0;
      end else begin
        pose_ch.ready <= 1'b1;
        if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, stall_max);
      end
    end
  end

  // monitor: predict on accepted command words, check accepted pose words
  always @(posedge clk) begin
    pose_word_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      cmd_fire = !rst && cmd_ch.valid && cmd_ch.ready;
      if (cmd_fire) begin
        if (odometry_step({cmd_ch.req_type, cmd_ch.pulse_dir, cmd_ch.yaw_angle}, want))
          pose_expected.push_back(want);
      end
      if (!rst && pose_ch.valid && pose_ch.ready) begin
        if (pose_expected.size() == 0) begin
          $error("pose word with nothing expected: x %0d y %0d heading %0d",
                 pose_ch.pose_x, pose_ch.pose_y, pose_ch.heading);
          errors++;
        end else begin
          want = pose_expected.pop_front();
          if (pose_ch.pose_x !== want.pose_x) begin
            $error("pose_x mismatch: expected %0d, got %0d", want.pose_x, pose_ch.pose_x);
            errors++;
          end
          if (pose_ch.pose_y !== want.pose_y) begin
            $error("pose_y mismatch: expected %0d, got %0d", want.pose_y, pose_ch.pose_y);
            errors++;
          end
          if (pose_ch.heading !== want.heading) begin
            $error("heading mismatch: expected %0d, got %0d", want.heading, pose_ch.heading);
            errors++;
          end
        end
      end
    end
  end

  task automatic write_scale(input logic idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    set_scale(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // sender holds off until every pose is back and the block has gone quiet
  task automatic drain();
    while (cmd_queue.size() != 0 || cmd_ch.valid || pose_expected.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly pulse runs closed by an update, some bare updates, some reserved noise
  task automatic queue_traffic(input int n);
    int done, k, bias, r;
    done = 0;
    while (done < n) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        k = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 12);
        case ($urandom_range(0, 3))
          0: bias = 0;
          1: bias = 100;
          2: bias = 50;
          default: bias = $urandom_range(0, 100);
        endcase
        for (int i = 0; i < k; i++)
          push_cmd($urandom_range(0, 1) ? REQ_RIGHT : REQ_LEFT,
                   $urandom_range(0, 99) < bias, YAW_W'($urandom_range(0, 65535)));
        push_cmd(REQ_UPDATE, 1'($urandom_range(0, 1)), pick_yaw());
        done += k + 1;
      end else if (r < 92) begin
        push_cmd(REQ_UPDATE, 1'($urandom_range(0, 1)), pick_yaw());
        done++;
      end else begin
        push_cmd(REQ_RESERVED, 1'($urandom_range(0, 1)), YAW_W'($urandom_range(0, 65535)));
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.req_type = REQ_LEFT;
    cmd_ch.pulse_dir = 1'b0;
    cmd_ch.yaw_angle = '0;
    pose_ch.ready = 1'b0;
    left_ticks = '0;
    right_ticks = '0;
    left_ticks_seen = '0;
    right_ticks_seen = '0;
    track_x = '0;
    track_y = '0;
    left_scale = LEFT_MPC_RESET;
    right_scale = RIGHT_MPC_RESET;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reserved words, zero travel, count wrap below zero, quadrant edges
    push_cmd(REQ_RESERVED, 1'b1, 16'hFFFF);
    push_cmd(REQ_UPDATE, 1'b0, 16'h0000);
    repeat (3) push_cmd(REQ_LEFT, 1'b1, 16'h0000);
    repeat (2) push_cmd(REQ_RIGHT, 1'b1, 16'hFFFF);
    push_cmd(REQ_UPDATE, 1'b1, 16'h4000);
    repeat (4) push_cmd(REQ_LEFT, 1'b0, 16'h5555);
    repeat (3) push_cmd(REQ_RIGHT, 1'b0, 16'hAAAA);
    push_cmd(REQ_UPDATE, 1'b0, 16'hFFFF);
    push_cmd(REQ_UPDATE, 1'b1, 16'h8000);
    push_cmd(REQ_RIGHT, 1'b1, 16'h0000);
    push_cmd(REQ_UPDATE, 1'b0, 16'hC000);
    push_cmd(REQ_LEFT, 1'b1, 16'h0000);
    push_cmd(REQ_UPDATE, 1'b1, 16'h3FFF);
    push_cmd(REQ_UPDATE, 1'b0, 16'h2000);
    push_cmd(REQ_RESERVED, 1'b0, 16'h0000);
    drain();

    queue_traffic(250);
    drain();

    write_scale(REG_LEFT_MPC, 32'd0);
    write_scale(REG_RIGHT_MPC, 32'd0);
    queue_traffic(200);
    drain();

    write_scale(REG_LEFT_MPC, CFG_DATA_W'(SCALE_MAX));
    write_scale(REG_RIGHT_MPC, CFG_DATA_W'(SCALE_MAX));
    queue_traffic(250);
    drain();

    write_scale(REG_LEFT_MPC, CFG_DATA_W'(SCALE_MAX));
    write_scale(REG_RIGHT_MPC, 32'd0);
    queue_traffic(200);
    drain();

    // upper bits beyond the register width are dropped
    write_scale(REG_LEFT_MPC, $urandom());
    write_scale(REG_RIGHT_MPC, $urandom());
    queue_traffic(200);
    drain();

    write_scale(REG_LEFT_MPC, $urandom_range(0, 4095));
    write_scale(REG_RIGHT_MPC, $urandom_range(0, 32'h3F_FFFF));
    queue_traffic(200);
    drain();

    write_scale(REG_LEFT_MPC, CFG_DATA_W'(LEFT_MPC_RESET));
    write_scale(REG_RIGHT_MPC, CFG_DATA_W'(RIGHT_MPC_RESET));
    queue_traffic(200);
    drain();

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
